[sv/shuffled_lcg_random_generator_top_assert.svh]
// assertion macros for the shuffled generator checker
`ifndef SHUFFLED_LCG_RANDOM_GENERATOR_TOP_ASSERT_SVH
`define SHUFFLED_LCG_RANDOM_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SLRG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("slrg assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define SLRG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("slrg assertion failed");

`endif

[sv/slrg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slrg_pkg;

	// request codes
	localparam logic REQ_SEED = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	localparam logic [31:0] MODULUS      = 32'h7FFF_FFFF;
	localparam logic signed [24:0] MULTIPLIER = 25'sd16807;
	localparam int unsigned FRAC_BITS    = 24;
	localparam int unsigned WARMUP_EXTRA = 7;

	// shared multiplier operands: 34 x 25 signed
	localparam int unsigned MUL_A_W = 34;
	localparam int unsigned MUL_B_W = 25;
	localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

	typedef struct packed {
		logic                      en;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

	// x * 16807 mod (2^31 - 1), from the product of x <= 2^31
	function automatic logic [30:0] mod_fold(input logic [45:0] p);
		logic [31:0] s;
		begin
			s = {1'b0, p[30:0]} + {17'd0, p[45:31]};
			if (s >= MODULUS)
				s = s - MODULUS;
			return s[30:0];
		end
	endfunction

	// floor(r * 2^24 / (2^31 - 1)) for r below the modulus
	function automatic logic [23:0] frac_of(input logic [30:0] r);
		logic [23:0] q0;
		logic [31:0] r0;
		begin
			q0 = r[30:7];
			r0 = {1'b0, r[6:0], 24'd0} + {8'd0, q0};
			if (r0 >= MODULUS)
				q0 = q0 + 24'd1;
			return q0;
		end
	endfunction

endpackage

`default_nettype wire

[sv/slrg_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface slrg_in_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic signed [31:0] seed_value;
	logic signed [31:0] range_low;
	logic signed [31:0] range_high;

	modport source (output valid, req_type, seed_value, range_low, range_high, input ready);
	modport sink (input valid, req_type, seed_value, range_low, range_high, output ready);
endinterface

`default_nettype wire

[sv/slrg_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface slrg_out_if;
	logic               valid;
	logic               ready;
	logic [30:0]        raw_value;
	logic signed [31:0] scaled_value;

	modport source (output valid, raw_value, scaled_value, input ready);
	modport sink (input valid, raw_value, scaled_value, output ready);
endinterface

`default_nettype wire

[sv/slrg_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

// shared signed multiplier with registered product
module slrg_mul (
	input  wire                                    clk,
	input  wire slrg_pkg::mul_req_t                mreq,
	output logic signed [slrg_pkg::PROD_W-1:0]     prod_q
);
	import slrg_pkg::*;

	always_ff @(posedge clk) begin
		if (mreq.en)
			prod_q <= $signed(mreq.a) * $signed(mreq.b);
	end
endmodule

`default_nettype wire

[sv/shuffled_lcg_random_generator_top.sv]
// seed load: no result, ready again the next cycle
// draw: steps are multiply and fold, index multiply and correction, swap, fraction,
//   scaling multiply and output; a new item is taken only once the result is handed over
// first draw after reset or seed load first runs a warm-up of multiply and fold that fills the table;
//   a result still held by the receiver stalls the output step
// arst_n clears the generator state, shuffle output and control; table is filled by warm-up
`timescale 1ns / 1ps
`default_nettype none

module shuffled_lcg_random_generator_top #(
	parameter int unsigned TABLE_ENTRIES = 32
) (
	input  wire        clk,
	input  wire        arst_n,
	slrg_in_if.sink    req,
	slrg_out_if.source rsp
);
	import slrg_pkg::*;

	localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + WARMUP_EXTRA + 1);
	// index divisor 1 + (M-1)/N; the shuffle output times its reciprocal gives
	// the index or one below it, one compare settles which
	localparam longint unsigned IDX_DIV = 64'd1 + 64'd2147483646 / TABLE_ENTRIES;
	localparam int unsigned     IDX_SH  = 23 + $clog2(IDX_DIV);
	localparam logic [23:0]     IDX_RCP = 24'((64'd1 << IDX_SH) / IDX_DIV);

	// sequencer codes
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL  = 4'd1; // multiplier takes x * 16807
	localparam logic [3:0] S_FOLD = 4'd2; // modular fold, warm-up write
	localparam logic [3:0] S_DIV  = 4'd3; // multiplier takes shuffle output * index reciprocal
	localparam logic [3:0] S_RD   = 4'd4; // swap: read old entry, write new value
	localparam logic [3:0] S_FRAC = 4'd5; // 24-bit fraction of the picked value
	localparam logic [3:0] S_SCL  = 4'd6; // multiplier takes frac * (high - low)
	localparam logic [3:0] S_OUT  = 4'd7; // shift, add low, saturate, hand over
	localparam logic [3:0] S_IDX  = 4'd8; // index estimate, raised by one if short

	logic [3:0]              state_q;
	logic signed [31:0]      gen_q;    // generator value
	logic [30:0]             shuf_q;   // shuffle output
	logic [31:0]             x_q;      // working generator value, up to 2^31
	logic [CNT_W-1:0]        cnt_q;    // warm-up step index, counts down
	logic                    warm_q;
	logic signed [31:0]      low_q;
	logic signed [32:0]      diff_q;
	logic [IDX_W-1:0]        quot_q;
	logic [23:0]             frac_q;
	logic [30:0]             rd_q;
	logic                    out_vld_q;
	logic [30:0]             out_raw_q;
	logic signed [31:0]      out_scl_q;

	// shuffle table, single write port with registered read
	logic [30:0]             tbl_mem [TABLE_ENTRIES];
	logic                    tbl_we;
	logic                    tbl_re;
	logic [IDX_W-1:0]        tbl_wa;
	logic [30:0]             tbl_wd;

	mul_req_t                mreq;
	logic signed [PROD_W-1:0] prod_q;

	logic [30:0]             fold_val;
	logic                    need_seed;
	logic signed [32:0]      neg_gen;
	logic [31:0]             start_x;
	logic [IDX_W-1:0]        idx_sel;
	logic [IDX_W-1:0]        q_est;
	logic [IDX_W:0]          q_inc;
	logic [39:0]             q_thr;
	logic                    q_up;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [33:0]      sum_w;
	logic signed [31:0]      sat_w;
	logic                    out_free;
	logic                    in_acc;

	slrg_mul u_mul (
		.clk    (clk),
		.mreq   (mreq),
		.prod_q (prod_q)
	);

	assign req.ready     = (state_q == S_IDLE);
	assign in_acc        = req.valid && req.ready;
	assign rsp.valid     = out_vld_q;
	assign rsp.raw_value = out_raw_q;
	assign rsp.scaled_value = out_scl_q;

	// output register is free when empty or being drained this cycle
	assign out_free = !out_vld_q || rsp.ready;

	assign fold_val = mod_fold(prod_q[45:0]);

	// reseed when the generator is not positive or nothing was drawn since seeding
	assign need_seed = (gen_q <= 32'sd0) || (shuf_q == 31'd0);
	assign neg_gen   = -$signed({gen_q[31], gen_q});
	assign start_x   = (neg_gen > 33'sd0) ? neg_gen[31:0] : 32'd1;

	// reciprocal estimate is exact or one short; compare against the next boundary
	assign q_est = prod_q[IDX_SH +: IDX_W];
	assign q_inc = {1'b0, q_est} + 1'b1;
	assign q_thr = 40'(q_inc) * 40'(IDX_DIV);
	assign q_up  = ({9'd0, shuf_q} >= q_thr);

	// index is below the table size by construction, clamp kept anyway
	assign idx_sel = ({1'b0, quot_q} >= (IDX_W + 1)'(TABLE_ENTRIES)) ?
		IDX_W'(TABLE_ENTRIES - 1) : quot_q;

	// floor shift by the fraction width, add low, saturate to 32 bits
	assign prod_sh = prod_q >>> FRAC_BITS;
	assign sum_w   = $signed({{2{low_q[31]}}, low_q}) + $signed(prod_sh[33:0]);
	always_comb begin
		if (sum_w > 34'sh0_7FFF_FFFF)
			sat_w = 32'sh7FFF_FFFF;
		else if (sum_w < -34'sh0_8000_0000)
			sat_w = -32'sh8000_0000;
		else
			sat_w = sum_w[31:0];
	end

	// shared multiplier operand select
	always_comb begin
		mreq.en = (state_q == S_MUL) || (state_q == S_DIV) || (state_q == S_SCL);
		if (state_q == S_SCL) begin
			mreq.a = {diff_q[32], diff_q};
			mreq.b = {1'b0, frac_q};
		end else if (state_q == S_DIV) begin
			mreq.a = {3'b000, shuf_q};
			mreq.b = {1'b0, IDX_RCP};
		end else begin
			mreq.a = {2'b00, x_q};
			mreq.b = MULTIPLIER;
		end
	end

	// table port control
	always_comb begin
		tbl_we = 1'b0;
		tbl_re = 1'b0;
		tbl_wa = idx_sel;
		tbl_wd = gen_q[30:0];
		case (state_q)
			S_FOLD: begin
				tbl_we = warm_q && (cnt_q < CNT_W'(TABLE_ENTRIES));
				tbl_wa = cnt_q[IDX_W-1:0];
				tbl_wd = fold_val;
			end
			S_RD: begin
				tbl_we = 1'b1;
				tbl_re = 1'b1;
			end
			default: begin
				tbl_we = 1'b0;
			end
		endcase
	end

	// read sees the old entry on a swap
	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_mem[tbl_wa] <= tbl_wd;
		if (tbl_re)
			rd_q <= tbl_mem[tbl_wa];
	end

	// control and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			gen_q     <= '0;
			shuf_q    <= '0;
			warm_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			// the output step reloads the register itself when it is drained
			if (out_vld_q && rsp.ready && (state_q != S_OUT))
				out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (req.req_type == REQ_SEED) begin
							// store the negated seed, zero and negatives as is
							gen_q  <= (req.seed_value <= 32'sd0) ? req.seed_value
								: -req.seed_value;
							shuf_q <= '0;
						end else begin
							low_q  <= req.range_low;
							diff_q <= $signed({req.range_high[31], req.range_high})
								- $signed({req.range_low[31], req.range_low});
							if (need_seed) begin
								x_q    <= start_x;
								warm_q <= 1'b1;
								cnt_q  <= CNT_W'(TABLE_ENTRIES + WARMUP_EXTRA);
							end else begin
								x_q    <= gen_q;
								warm_q <= 1'b0;
							end
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					x_q <= {1'b0, fold_val};
					if (warm_q) begin
						if (cnt_q == '0) begin
							// last warm-up value is entry 0 and the shuffle output
							shuf_q <= fold_val;
							warm_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
						state_q <= S_MUL;
					end else begin
						gen_q   <= {1'b0, fold_val};
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					state_q <= S_IDX;
				end
				S_IDX: begin
					quot_q  <= q_up ? q_inc[IDX_W-1:0] : q_est;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_FRAC;
				end
				S_FRAC: begin
					shuf_q  <= rd_q;
					frac_q  <= frac_of(rd_q);
					state_q <= S_SCL;
				end
				S_SCL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_raw_q <= shuf_q;
						out_scl_q <= sat_w;
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

`default_nettype wire

[sv/slrg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "shuffled_lcg_random_generator_top_assert.svh"

module slrg_sva (
	input wire        clk,
	input wire        arst_n,
	input wire        req_valid,
	input wire        req_ready,
	input wire        req_type,
	input wire        rsp_valid,
	input wire        rsp_ready,
	input wire [30:0] raw_value,
	input wire [31:0] scaled_value
);
	import slrg_pkg::*;

	// held item does not change
	`SLRG_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({raw_value, scaled_value}))
	// a draw keeps the block busy
	`SLRG_ASSERT_NXT(a_draw_busy, req_valid && req_ready && (req_type == REQ_DRAW), !req_ready)
	// a seed load finishes at once
	`SLRG_ASSERT_NXT(a_seed_quick, req_valid && req_ready && (req_type == REQ_SEED), req_ready)
	// a new result comes together with the return to idle
	`SLRG_ASSERT_NOW(a_rsp_idle, $rose(rsp_valid), $rose(req_ready))
	// raw value is always below the modulus
	`SLRG_ASSERT_NOW(a_raw_range, rsp_valid, raw_value != 31'h7FFF_FFFF)
endmodule

bind shuffled_lcg_random_generator_top slrg_sva u_slrg_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_type     (req.req_type),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.raw_value    (rsp.raw_value),
	.scaled_value (rsp.scaled_value)
);

`default_nettype wire

[tb/slrg_checker.sv]
`timescale 1ns / 1ps

module slrg_checker #(
	parameter int unsigned TABLE_ENTRIES = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	slrg_in_if          req,
	slrg_out_if         rsp,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned draws_checked
);

	localparam longint GEN_MOD     = longint'(slrg_pkg::MODULUS);
	localparam longint GEN_MUL     = 16807;
	localparam int     WARMUP_RUNS = TABLE_ENTRIES + slrg_pkg::WARMUP_EXTRA;
	localparam longint SLOT_DIV    = 1 + (GEN_MOD - 1) / TABLE_ENTRIES;
	localparam int     FRAC_W      = slrg_pkg::FRAC_BITS;

	typedef struct packed {
		logic        [30:0] raw;
		logic signed [31:0] scaled;
	} draw_result_t;

	// generator model state
	longint      gen_state;
	logic [30:0] shuf_out;
	logic [30:0] shuf_table [TABLE_ENTRIES];

	draw_result_t expected_draws [$];
	int unsigned  mismatches;
	int unsigned  compared;

	function automatic longint minstd_next(input longint x);
		return (x * GEN_MUL) % GEN_MOD;
	endfunction

	function automatic draw_result_t predict_draw(input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		longint       x;
		longint       slot;
		longint       frac;
		longint       total;
		int           i;
		draw_result_t r;
		x = gen_state;
		// refill the table after reset or a seed load
		if (x <= 0 || shuf_out == '0) begin
			x = (-x < 1) ? 1 : -x;
			for (i = WARMUP_RUNS; i >= 0; i--) begin
				x = minstd_next(x);
				if (i < TABLE_ENTRIES)
					shuf_table[i] = x[30:0];
			end
			shuf_out = shuf_table[0];
		end
		x = minstd_next(x);
		gen_state = x;
		slot = longint'(shuf_out) / SLOT_DIV;
		if (slot >= TABLE_ENTRIES)
			slot = TABLE_ENTRIES - 1;
		shuf_out = shuf_table[slot];
		shuf_table[slot] = x[30:0];
		// arithmetic shift of a signed product rounds toward minus infinity
		frac = (longint'(shuf_out) << FRAC_W) / GEN_MOD;
		total = longint'(lo) + ((frac * (longint'(hi) - longint'(lo))) >>> FRAC_W);
		if (total > 64'sd2147483647)
			total = 64'sd2147483647;
		if (total < -64'sd2147483648)
			total = -64'sd2147483648;
		r.raw = shuf_out;
		r.scaled = total[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		draw_result_t want;
		if (!arst_n) begin
			gen_state = 0;
			shuf_out = '0;
			foreach (shuf_table[k])
				shuf_table[k] = '0;
			expected_draws.delete();
			mismatches = 0;
			compared = 0;
			fail_count <= 0;
			pending <= 0;
			draws_checked <= 0;
		end else begin
			// results first: nothing accepted at this edge can already be out
			if (rsp.valid && rsp.ready) begin
				if (expected_draws.size() == 0) begin
					$display("%0t: unexpected result raw %h scaled %h", $time,
						rsp.raw_value, rsp.scaled_value);
					mismatches++;
				end else begin
					want = expected_draws.pop_front();
					compared++;
					if (rsp.raw_value !== want.raw) begin
						$display("%0t: raw_value mismatch, expected %h, got %h", $time,
							want.raw, rsp.raw_value);
						mismatches++;
					end
					if (rsp.scaled_value !== want.scaled) begin
						$display("%0t: scaled_value mismatch, expected %h, got %h", $time,
							want.scaled, rsp.scaled_value);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.req_type == slrg_pkg::REQ_SEED) begin
					gen_state = (req.seed_value <= 0) ? longint'(req.seed_value)
						: -longint'(req.seed_value);
					shuf_out = '0;
				end else begin
					expected_draws.push_back(predict_draw(req.range_low, req.range_high));
				end
			end
			fail_count <= mismatches;
			pending <= expected_draws.size();
			draws_checked <= compared;
		end
	end

endmodule

[tb/shuffled_lcg_random_generator_top_tb.sv]
`timescale 1ns / 1ps

module shuffled_lcg_random_generator_top_tb;
	import slrg_pkg::*;

	localparam int unsigned TABLE_ENTRIES = 32;
	// long output hold, long enough for the block to fill and stall its input
	localparam int unsigned HOLD_CYCLES = 300;
	// worst tail: a warm-up refill plus the draw latency, with margin
	localparam int unsigned TAIL_CYCLES = 200;

	logic clk;
	logic arst_n;

	slrg_in_if  req_ch ();
	slrg_out_if rsp_ch ();

	int unsigned fail_count;
	int unsigned pending;
	int unsigned draws_checked;

	// rates of the current phase, in percent of cycles
	int unsigned send_idle_pct;
	int unsigned rsp_stall_pct;
	logic        long_hold;
	int unsigned hold_count;

	int unsigned n_items;
	int unsigned n_seeds;

	shuffled_lcg_random_generator_top #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	slrg_checker #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(fail_count),
		.pending(pending),
		.draws_checked(draws_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	// receiver: random stalls, plus one long hold counted here
	initial begin
		rsp_ch.ready = 1'b0;
		hold_count = 0;
		forever begin
			@(posedge clk);
			if (long_hold && hold_count < HOLD_CYCLES) begin
				rsp_ch.ready <= 1'b0;
				hold_count++;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	// offer one item, idling first at the phase rate, and wait for acceptance
	// valid stays high from one item to the next unless an idle cycle comes in
	task automatic push_item(input logic kind, input logic signed [31:0] seed,
			input logic signed [31:0] lo, input logic signed [31:0] hi);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.seed_value <= seed;
		req_ch.range_low <= lo;
		req_ch.range_high <= hi;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		n_items++;
		if (kind == REQ_SEED)
			n_seeds++;
	endtask

	task automatic draw(input logic signed [31:0] lo, input logic signed [31:0] hi);
		push_item(REQ_DRAW, $urandom, lo, hi);
	endtask

	// seed loads carry random range fields, which the block ignores
	task automatic seed_load(input logic signed [31:0] seed);
		push_item(REQ_SEED, seed, $urandom, $urandom);
	endtask

	// sender pause: hold valid low until every expected result is back
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// mostly draws with varied ranges; a few seed loads, special seeds among them
	task automatic send_random();
		int unsigned        pick;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic signed [31:0] seed;
		pick = $urandom_range(99);
		lo = $urandom;
		hi = $urandom;
		seed = $urandom;
		case ($urandom_range(3))
			0: begin
				// full 32-bit bounds, either order
			end
			1: begin
				// small integer range in Q16.16
				lo = (int'($urandom_range(400)) - 200) * 65536;
				hi = lo + int'($urandom_range(1, 100)) * 65536;
			end
			2: begin
				// reversed small range
				hi = (int'($urandom_range(400)) - 200) * 65536;
				lo = hi + int'($urandom_range(100)) * 65536;
			end
			default: begin
				// bounds differ only in a random number of low bits, often close together
				hi = lo ^ ($urandom >> $urandom_range(31));
			end
		endcase
		if (pick < 8) begin
			case ($urandom_range(7))
				0: seed = 32'sd0;
				1: seed = 32'sh7FFF_FFFF;
				2: seed = 32'sh8000_0000;
				3: seed = int'($urandom_range(1, 1000));
				4: seed = -int'($urandom_range(1, 1000));
				default: begin
					// random seed as drawn
				end
			endcase
			push_item(REQ_SEED, seed, lo, hi);
		end else begin
			push_item(REQ_DRAW, seed, lo, hi);
		end
	endtask

	task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned count);
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		repeat (count)
			send_random();
		drain();
	endtask

	initial begin
		// every input known from time zero
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_DRAW;
		req_ch.seed_value = '0;
		req_ch.range_low = '0;
		req_ch.range_high = '0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		long_hold = 1'b0;
		n_items = 0;
		n_seeds = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: draw straight out of reset restarts the generator from one
		draw(32'sd0, 32'sh0001_0000);
		// widest range, then fully reversed, then a zero-width range at the top
		draw(32'sh8000_0000, 32'sh7FFF_FFFF);
		draw(32'sh7FFF_FFFF, 32'sh8000_0000);
		draw(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		// zero seed behaves like a fresh start
		seed_load(32'sd0);
		draw(32'sd0, 32'sh0064_0000);
		// positive and negative seeds of magnitude one give the same sequence
		seed_load(32'sd1);
		draw(32'sd0, 32'sh0064_0000);
		draw(32'sd0, 32'sh0064_0000);
		seed_load(-32'sd1);
		draw(32'sd0, 32'sh0064_0000);
		// seed equal to the modulus: generator collapses to zero, scaled equals low
		seed_load(32'sh7FFF_FFFF);
		draw(-32'sh0010_0000, 32'sh0010_0000);
		// next draw sees the zero state and restarts from one
		draw(-32'sh0010_0000, 32'sh0010_0000);
		// most negative seed starts from two to the 31st
		seed_load(32'sh8000_0000);
		draw(32'sh8000_0000, 32'sh7FFF_FFFF);
		seed_load(-32'sd2147483647);
		draw(32'sd0, 32'sh7FFF_FFFF);
		// reversed signed range and a range pinned at the bottom
		seed_load(32'sd12345);
		draw(32'sh0064_0000, -32'sh0064_0000);
		draw(32'sh8000_0000, 32'sh8000_0000);
		draw(32'sh8000_0000, 32'sd0);
		drain();

		// no idling; the receiver opens with a long hold so the input backs up
		long_hold = 1'b1;
		run_phase(0, 0, 250);
		// sender mostly idle
		run_phase(86, 0, 200);
		// receiver mostly stalling
		run_phase(0, 86, 250);
		// light idling on both sides
		run_phase(12, 12, 250);

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d items: %0d draws checked, %0d seed loads, special seeds,",
			n_items, draws_checked, n_seeds);
		$display("reversed and extreme ranges, four handshake-rate phases and a long hold");
		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/slrg_pkg.sv
sv/slrg_in_if.sv
sv/slrg_out_if.sv
sv/slrg_mul.sv
sv/shuffled_lcg_random_generator_top.sv
sv/slrg_checker.sv
tb/slrg_checker.sv
tb/shuffled_lcg_random_generator_top_tb.sv
